FILE: hw/rtl/ltm_pkg.sv
package ltm_pkg;

  // field widths fixed by the interface
  localparam int CMD_W   = 2;
  localparam int PT_W    = 17;
  localparam int VIEW_W  = 16;
  localparam int GUEST_W = 13;
  localparam int PIX_W   = 12;
  localparam int CFG_W   = 16;

  // shared arithmetic unit widths
  localparam int MUL_A_W = 18;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 36;

  // default largest guest size accepted
  localparam int GUEST_MAX_DEF = 4096;

  // configuration reset values
  localparam logic [VIEW_W-1:0]  VIEW_W_RST  = 16'd5120;
  localparam logic [VIEW_W-1:0]  VIEW_H_RST  = 16'd7680;
  localparam logic [GUEST_W-1:0] GUEST_W_RST = 13'd320;
  localparam logic [GUEST_W-1:0] GUEST_H_RST = 13'd480;

  typedef enum logic [CMD_W-1:0] {
    PH_BEGAN     = 2'd0,
    PH_MOVED     = 2'd1,
    PH_ENDED     = 2'd2,
    PH_CANCELLED = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    CFG_VIEW_WIDTH   = 2'd0,
    CFG_VIEW_HEIGHT  = 2'd1,
    CFG_GUEST_WIDTH  = 2'd2,
    CFG_GUEST_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_LOAD_X2,
    ACC_SUB,
    ACC_ADD,
    ACC_DIV
  } acc_op_e;

  typedef struct packed {
    logic    mul_en;
    acc_op_e acc_op;
  } alu_ctrl_t;

  typedef struct packed {
    logic [VIEW_W-1:0]  vw;
    logic [VIEW_W-1:0]  vh;
    logic [GUEST_W-1:0] gw;
    logic [GUEST_W-1:0] gh;
  } cfg_t;

  typedef struct packed {
    phase_e             phase;
    logic               hit;
    logic [PIX_W-1:0]   col;
    logic [PIX_W-1:0]   row;
  } map_res_t;

endpackage

FILE: hw/rtl/ltm_if.sv
// touch event word
interface ltm_evt_if;
  logic                              valid;
  logic                              ready;
  ltm_pkg::phase_e                   cmd;
  logic signed [ltm_pkg::PT_W-1:0]   point_x;
  logic signed [ltm_pkg::PT_W-1:0]   point_y;

  modport source (output valid, cmd, point_x, point_y, input ready);
  modport sink   (input valid, cmd, point_x, point_y, output ready);
endinterface

// guest report word
interface ltm_res_if;
  logic                          valid;
  logic                          ready;
  logic                          report;
  logic [ltm_pkg::PIX_W-1:0]     guest_x;
  logic [ltm_pkg::PIX_W-1:0]     guest_y;
  logic                          inside_res;

  modport source (output valid, report, guest_x, guest_y, inside_res, input ready);
  modport sink   (input valid, report, guest_x, guest_y, inside_res, output ready);
endinterface

FILE: hw/rtl/letterbox_touch_map_and_track_top.sv
// Letterbox touch mapping and gesture tracking.
// Touch event words come in on evt_i (cmd, point_x, point_y in Q12.4);
// one report word per event leaves on res_o (report, guest_x, guest_y,
// inside_res). Both channels move a word when valid and ready are high.
// The view and guest sizes are written through cfg_we_i / cfg_idx_i /
// cfg_wdata_i; the user must write them only while no event is in
// flight, as the block itself does not enforce it. One event is mapped
// at a time by a single shared multiplier and accumulator under a
// sequencer: the limiting-axis cross products (S_CR0 to S_CR2), then per
// axis a multiply-accumulate (S_M0 to S_M3), a range check, restoring
// division of QW quotient bits (QW = clog2(GUEST_MAX), 12 by default)
// and a bounds check, then a hand-off. The mapper returns to idle
// before the next accept; a bad configuration or an early outside point
// ends the sequence early.
// evt_i.ready is high only while the mapper is idle. The result sits in
// an output register, so the next event is accepted while it waits;
// when res_o stalls, the mapper holds its finished result until the
// register frees. Reset restores the default sizes and ends any gesture.
module letterbox_touch_map_and_track_top #(
  parameter int GUEST_MAX = ltm_pkg::GUEST_MAX_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [ltm_pkg::CFG_W-1:0]    cfg_wdata_i,
  ltm_evt_if.sink                      evt_i,
  ltm_res_if.source                    res_o
);

  ltm_pkg::cfg_t                          cfg_q;
  ltm_pkg::alu_ctrl_t                     alu_ctrl;
  ltm_pkg::map_res_t                      map_res;
  logic signed [ltm_pkg::MUL_A_W-1:0]     mul_a;
  logic signed [ltm_pkg::MUL_B_W-1:0]     mul_b;
  logic [ltm_pkg::ACC_W-2:0]              ds;
  logic signed [ltm_pkg::PROD_W-1:0]      prod;
  logic signed [ltm_pkg::ACC_W-1:0]       acc;
  logic                                   qbit;
  logic                                   map_ready, map_done, trk_ready, start;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vw <= ltm_pkg::VIEW_W_RST;
      cfg_q.vh <= ltm_pkg::VIEW_H_RST;
      cfg_q.gw <= ltm_pkg::GUEST_W_RST;
      cfg_q.gh <= ltm_pkg::GUEST_H_RST;
    end else if (cfg_we_i) begin
      unique case (ltm_pkg::cfg_idx_e'(cfg_idx_i))
        ltm_pkg::CFG_VIEW_WIDTH:   cfg_q.vw <= cfg_wdata_i;
        ltm_pkg::CFG_VIEW_HEIGHT:  cfg_q.vh <= cfg_wdata_i;
        ltm_pkg::CFG_GUEST_WIDTH:  cfg_q.gw <= cfg_wdata_i[ltm_pkg::GUEST_W-1:0];
        ltm_pkg::CFG_GUEST_HEIGHT: cfg_q.gh <= cfg_wdata_i[ltm_pkg::GUEST_W-1:0];
        default: ;
      endcase
    end
  end

  assign evt_i.ready = map_ready;
  assign start       = evt_i.valid && map_ready;

  ltm_alu u_alu (
    .clk_i   (clk_i),
    .ctrl_i  (alu_ctrl),
    .mul_a_i (mul_a),
    .mul_b_i (mul_b),
    .ds_i    (ds),
    .prod_o  (prod),
    .acc_o   (acc),
    .qbit_o  (qbit)
  );

  ltm_map #(
    .GUEST_MAX (GUEST_MAX)
  ) u_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .start_i     (start),
    .cmd_i       (evt_i.cmd),
    .point_x_i   (evt_i.point_x),
    .point_y_i   (evt_i.point_y),
    .ready_o     (map_ready),
    .done_o      (map_done),
    .res_o       (map_res),
    .trk_ready_i (trk_ready),
    .alu_ctrl_o  (alu_ctrl),
    .mul_a_o     (mul_a),
    .mul_b_o     (mul_b),
    .ds_o        (ds),
    .prod_i      (prod),
    .acc_i       (acc),
    .qbit_i      (qbit)
  );

  ltm_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .done_i      (map_done),
    .res_i       (map_res),
    .trk_ready_o (trk_ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .report_o    (res_o.report),
    .guest_x_o   (res_o.guest_x),
    .guest_y_o   (res_o.guest_y),
    .inside_o    (res_o.inside_res)
  );

endmodule

FILE: hw/rtl/ltm_alu.sv
module ltm_alu (
  input  logic                                 clk_i,
  input  ltm_pkg::alu_ctrl_t                   ctrl_i,
  input  logic signed [ltm_pkg::MUL_A_W-1:0]   mul_a_i,
  input  logic signed [ltm_pkg::MUL_B_W-1:0]   mul_b_i,
  input  logic [ltm_pkg::ACC_W-2:0]            ds_i,
  output logic signed [ltm_pkg::PROD_W-1:0]    prod_o,
  output logic signed [ltm_pkg::ACC_W-1:0]     acc_o,
  output logic                                 qbit_o
);

  logic signed [ltm_pkg::PROD_W-1:0] prod_q;
  logic signed [ltm_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic signed [ltm_pkg::ACC_W-1:0]  prod_ext, ds_ext;

  assign prod_ext = ltm_pkg::ACC_W'(prod_q);
  assign ds_ext   = $signed({1'b0, ds_i});

  // restoring divide step: subtract shifted divisor when it fits
  assign qbit_o = (acc_q >= ds_ext);

  // accumulator next value
  always_comb begin
    acc_d = acc_q;
    case (ctrl_i.acc_op)
      ltm_pkg::ACC_LOAD:    acc_d = prod_ext;
      ltm_pkg::ACC_LOAD_X2: acc_d = prod_ext <<< 1;
      ltm_pkg::ACC_SUB:     acc_d = acc_q - prod_ext;
      ltm_pkg::ACC_ADD:     acc_d = acc_q + prod_ext;
      ltm_pkg::ACC_DIV:     acc_d = qbit_o ? (acc_q - ds_ext) : acc_q;
      default:              acc_d = acc_q;
    endcase
  end

  // product and accumulator registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= mul_a_i * mul_b_i;
    end
    acc_q <= acc_d;
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

FILE: hw/rtl/ltm_map.sv
module ltm_map #(
  parameter int GUEST_MAX = ltm_pkg::GUEST_MAX_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ltm_pkg::cfg_t                        cfg_i,
  input  logic                                 start_i,
  input  ltm_pkg::phase_e                      cmd_i,
  input  logic signed [ltm_pkg::PT_W-1:0]      point_x_i,
  input  logic signed [ltm_pkg::PT_W-1:0]      point_y_i,
  output logic                                 ready_o,
  output logic                                 done_o,
  output ltm_pkg::map_res_t                    res_o,
  input  logic                                 trk_ready_i,
  output ltm_pkg::alu_ctrl_t                   alu_ctrl_o,
  output logic signed [ltm_pkg::MUL_A_W-1:0]   mul_a_o,
  output logic signed [ltm_pkg::MUL_B_W-1:0]   mul_b_o,
  output logic [ltm_pkg::ACC_W-2:0]            ds_o,
  input  logic signed [ltm_pkg::PROD_W-1:0]    prod_i,
  input  logic signed [ltm_pkg::ACC_W-1:0]     acc_i,
  input  logic                                 qbit_i
);

  localparam int QW  = $clog2(GUEST_MAX);
  localparam int CW  = $clog2(QW);
  localparam int CMW = 17;

  typedef enum logic [3:0] {
    S_IDLE, S_CR0, S_CR1, S_CR2, S_M0, S_M1, S_M2, S_M3, S_CHK, S_DV, S_FIN, S_DONE
  } state_e;

  state_e                            state_q, state_d;
  ltm_pkg::phase_e                   cmd_q, cmd_d;
  logic signed [ltm_pkg::PT_W-1:0]   px_q, px_d, py_q, py_d;
  logic                              horiz_q, horiz_d;
  logic                              axis_q, axis_d;
  logic [ltm_pkg::ACC_W-2:0]         ds_q, ds_d;
  logic [CW-1:0]                     cnt_q, cnt_d;
  logic [QW-1:0]                     quo_q, quo_d;
  logic                              inside_q, inside_d;
  logic [ltm_pkg::PIX_W-1:0]         col_q, col_d, row_q, row_d;

  logic [ltm_pkg::VIEW_W-1:0]        vs, v;
  logic [ltm_pkg::GUEST_W-1:0]       gs, g;
  logic signed [ltm_pkg::PT_W-1:0]   p;
  logic [ltm_pkg::ACC_W-2:0]         d2_ext, lim, ds_init;
  logic                              bad_cfg, n_ok, fin_ok;
  logic [CMW-1:0]                    quo_ext;

  // limiting-axis and mapped-axis sizes
  assign vs = horiz_q ? cfg_i.vw : cfg_i.vh;
  assign gs = horiz_q ? cfg_i.gw : cfg_i.gh;
  assign v  = axis_q ? cfg_i.vh : cfg_i.vw;
  assign g  = axis_q ? cfg_i.gh : cfg_i.gw;
  assign p  = axis_q ? py_q : px_q;

  // divisor 2*vs and the bound that keeps the quotient in QW bits
  assign d2_ext  = (ltm_pkg::ACC_W-1)'({vs, 1'b0});
  assign lim     = d2_ext << QW;
  assign ds_init = d2_ext << (QW - 1);

  assign bad_cfg = (cfg_i.vw == '0) || (cfg_i.vh == '0) || (cfg_i.gw == '0)
                || (cfg_i.gh == '0)
                || (CMW'(cfg_i.gw) > CMW'(GUEST_MAX)) || (CMW'(cfg_i.gh) > CMW'(GUEST_MAX));

  assign n_ok    = !acc_i[ltm_pkg::ACC_W-1] && (acc_i[ltm_pkg::ACC_W-2:0] < lim);
  assign quo_ext = CMW'(quo_q);
  assign fin_ok  = quo_ext < CMW'(g);

  // sequencer
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    px_d      = px_q;
    py_d      = py_q;
    horiz_d   = horiz_q;
    axis_d    = axis_q;
    ds_d      = ds_q;
    cnt_d     = cnt_q;
    quo_d     = quo_q;
    inside_d  = inside_q;
    col_d     = col_q;
    row_d     = row_q;
    alu_ctrl_o.mul_en = 1'b0;
    alu_ctrl_o.acc_op = ltm_pkg::ACC_HOLD;
    mul_a_o   = $signed({2'b00, cfg_i.vw});
    mul_b_o   = $signed({4'b0000, cfg_i.gh});
    done_o    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d    = cmd_i;
          px_d     = point_x_i;
          py_d     = point_y_i;
          axis_d   = 1'b0;
          inside_d = 1'b0;
          state_d  = bad_cfg ? S_DONE : S_CR0;
        end
      end
      // cross products pick the limiting axis
      S_CR0: begin
        alu_ctrl_o.mul_en = 1'b1;
        mul_a_o = $signed({2'b00, cfg_i.vw});
        mul_b_o = $signed({4'b0000, cfg_i.gh});
        state_d = S_CR1;
      end
      S_CR1: begin
        alu_ctrl_o.mul_en = 1'b1;
        alu_ctrl_o.acc_op = ltm_pkg::ACC_LOAD;
        mul_a_o = $signed({2'b00, cfg_i.vh});
        mul_b_o = $signed({4'b0000, cfg_i.gw});
        state_d = S_CR2;
      end
      S_CR2: begin
        horiz_d = (acc_i <= ltm_pkg::ACC_W'(prod_i));
        state_d = S_M0;
      end
      // numerator 2*p*gs - v*gs + g*vs
      S_M0: begin
        alu_ctrl_o.mul_en = 1'b1;
        mul_a_o = $signed({p[ltm_pkg::PT_W-1], p});
        mul_b_o = $signed({4'b0000, gs});
        state_d = S_M1;
      end
      S_M1: begin
        alu_ctrl_o.mul_en = 1'b1;
        alu_ctrl_o.acc_op = ltm_pkg::ACC_LOAD_X2;
        mul_a_o = $signed({2'b00, v});
        mul_b_o = $signed({4'b0000, gs});
        state_d = S_M2;
      end
      S_M2: begin
        alu_ctrl_o.mul_en = 1'b1;
        alu_ctrl_o.acc_op = ltm_pkg::ACC_SUB;
        mul_a_o = $signed({5'b00000, g});
        mul_b_o = $signed({1'b0, vs});
        state_d = S_M3;
      end
      S_M3: begin
        alu_ctrl_o.acc_op = ltm_pkg::ACC_ADD;
        state_d = S_CHK;
      end
      // negative or too large numerators are outside
      S_CHK: begin
        if (n_ok) begin
          ds_d    = ds_init;
          cnt_d   = CW'(QW - 1);
          quo_d   = '0;
          state_d = S_DV;
        end else begin
          inside_d = 1'b0;
          state_d  = S_DONE;
        end
      end
      // one quotient bit a cycle
      S_DV: begin
        alu_ctrl_o.acc_op = ltm_pkg::ACC_DIV;
        quo_d = {quo_q[QW-2:0], qbit_i};
        ds_d  = ds_q >> 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!fin_ok) begin
          inside_d = 1'b0;
          state_d  = S_DONE;
        end else if (!axis_q) begin
          col_d   = quo_ext[ltm_pkg::PIX_W-1:0];
          axis_d  = 1'b1;
          state_d = S_M0;
        end else begin
          row_d    = quo_ext[ltm_pkg::PIX_W-1:0];
          inside_d = 1'b1;
          state_d  = S_DONE;
        end
      end
      S_DONE: begin
        if (trk_ready_i) begin
          done_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cmd_q    <= ltm_pkg::PH_BEGAN;
      px_q     <= '0;
      py_q     <= '0;
      horiz_q  <= 1'b0;
      axis_q   <= 1'b0;
      ds_q     <= '0;
      cnt_q    <= '0;
      quo_q    <= '0;
      inside_q <= 1'b0;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      state_q  <= state_d;
      cmd_q    <= cmd_d;
      px_q     <= px_d;
      py_q     <= py_d;
      horiz_q  <= horiz_d;
      axis_q   <= axis_d;
      ds_q     <= ds_d;
      cnt_q    <= cnt_d;
      quo_q    <= quo_d;
      inside_q <= inside_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  assign ready_o      = (state_q == S_IDLE);
  assign ds_o         = ds_q;
  assign res_o.phase  = cmd_q;
  assign res_o.hit    = inside_q;
  assign res_o.col    = col_q;
  assign res_o.row    = row_q;

  // remainder never goes negative while dividing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DV |-> !acc_i[ltm_pkg::ACC_W-1])
    else $error("divider remainder went negative");

  // an accepted word makes the unit busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && ready_o |=> !ready_o)
    else $error("mapper still ready after accepting a word");

endmodule

FILE: hw/rtl/ltm_track.sv
module ltm_track (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        done_i,
  input  ltm_pkg::map_res_t           res_i,
  output logic                        trk_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        report_o,
  output logic [ltm_pkg::PIX_W-1:0]   guest_x_o,
  output logic [ltm_pkg::PIX_W-1:0]   guest_y_o,
  output logic                        inside_o
);

  logic                        active_q, active_d;
  logic [ltm_pkg::PIX_W-1:0]   last_col_q, last_col_d, last_row_q, last_row_d;
  logic                        out_valid_q, out_valid_d;
  logic                        report_q, report_d, inside_q, inside_d;
  logic [ltm_pkg::PIX_W-1:0]   x_q, x_d, y_q, y_d;
  logic                        began, take, rep;

  assign began = (res_i.phase == ltm_pkg::PH_BEGAN);
  assign take  = res_i.hit && (began || active_q);
  assign rep   = began ? res_i.hit
               : (active_q && (res_i.hit || (res_i.phase != ltm_pkg::PH_MOVED)));

  // gesture tracker and output register
  always_comb begin
    active_d    = active_q;
    last_col_d  = last_col_q;
    last_row_d  = last_row_q;
    report_d    = report_q;
    inside_d    = inside_q;
    x_d         = x_q;
    y_d         = y_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (done_i) begin
      active_d    = began ? res_i.hit : (active_q && (res_i.phase == ltm_pkg::PH_MOVED));
      last_col_d  = take ? res_i.col : last_col_q;
      last_row_d  = take ? res_i.row : last_row_q;
      report_d    = rep;
      inside_d    = res_i.hit;
      x_d         = rep ? last_col_d : '0;
      y_d         = rep ? last_row_d : '0;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      last_col_q  <= '0;
      last_row_q  <= '0;
      out_valid_q <= 1'b0;
      report_q    <= 1'b0;
      inside_q    <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
    end else begin
      active_q    <= active_d;
      last_col_q  <= last_col_d;
      last_row_q  <= last_row_d;
      out_valid_q <= out_valid_d;
      report_q    <= report_d;
      inside_q    <= inside_d;
      x_q         <= x_d;
      y_q         <= y_d;
    end
  end

  assign trk_ready_o = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign report_o    = report_q;
  assign guest_x_o   = x_q;
  assign guest_y_o   = y_q;
  assign inside_o    = inside_q;

  // unreported words carry a zero position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !report_q |-> (x_q == '0) && (y_q == '0))
    else $error("unreported word has a nonzero position");

  // the mapper only hands over when the output register has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> (!out_valid_q || out_ready_i))
    else $error("result handed over while output register is full");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ltm_pkg::*;

  // one report word as seen on the result channel
  typedef struct packed {
    logic             report;
    logic [PIX_W-1:0] guest_x;
    logic [PIX_W-1:0] guest_y;
    logic             inside_res;
  } touch_report_t;

  // letterbox mapping and gesture tracking, plus the queue of pending report words
  class touch_report_board;
    logic [VIEW_W-1:0]  view_w;
    logic [VIEW_W-1:0]  view_h;
    logic [GUEST_W-1:0] guest_w;
    logic [GUEST_W-1:0] guest_h;
    bit                 gesture_on;
    logic [PIX_W-1:0]   last_col;
    logic [PIX_W-1:0]   last_row;
    touch_report_t      expected_reports[$];
    int unsigned        fails;

    function new();
      view_w     = VIEW_W_RST;
      view_h     = VIEW_H_RST;
      guest_w    = GUEST_W_RST;
      guest_h    = GUEST_H_RST;
      gesture_on = 1'b0;
      last_col   = '0;
      last_row   = '0;
      fails      = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_VIEW_WIDTH:   view_w  = data;
        CFG_VIEW_HEIGHT:  view_h  = data;
        CFG_GUEST_WIDTH:  guest_w = data[GUEST_W-1:0];
        CFG_GUEST_HEIGHT: guest_h = data[GUEST_W-1:0];
        default: ;
      endcase
    endfunction

    // division rounding toward minus infinity, divisor always positive
    function longint floor_quot(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
    endfunction

    // aspect fit of one host point into guest pixels, 1 when inside
    function bit fit_point(longint px, longint py, output logic [PIX_W-1:0] col,
                           output logic [PIX_W-1:0] row);
      longint vw, vh, gw, gh, vs, gs, x, y;
      vw  = view_w;
      vh  = view_h;
      gw  = guest_w;
      gh  = guest_h;
      col = '0;
      row = '0;
      if (vw == 0 || vh == 0 || gw == 0 || gh == 0) return 1'b0;
      if (gw > GUEST_MAX_DEF || gh > GUEST_MAX_DEF) return 1'b0;
      // limiting axis by cross product
      if (vw * gh <= vh * gw) begin
        vs = vw;
        gs = gw;
      end else begin
        vs = vh;
        gs = gh;
      end
      x = floor_quot(2 * px * gs - vw * gs + gw * vs, 2 * vs);
      y = floor_quot(2 * py * gs - vh * gs + gh * vs, 2 * vs);
      if (x < 0 || y < 0 || x >= gw || y >= gh) return 1'b0;
      col = x[PIX_W-1:0];
      row = y[PIX_W-1:0];
      return 1'b1;
    endfunction

    // accepted event word: map it, step the tracker, queue the report
    function void note_touch(phase_e ph, logic signed [PT_W-1:0] px,
                             logic signed [PT_W-1:0] py);
      logic [PIX_W-1:0] col, row;
      bit               hit;
      touch_report_t    r;
      hit          = fit_point(longint'(px), longint'(py), col, row);
      r            = '0;
      r.inside_res = hit;
      if (ph == PH_BEGAN) begin
        gesture_on = hit;
        if (hit) begin
          last_col = col;
          last_row = row;
          r.report = 1'b1;
        end
      end else if (gesture_on) begin
        if (hit) begin
          last_col = col;
          last_row = row;
          r.report = 1'b1;
        end else if (ph != PH_MOVED) begin
          r.report = 1'b1;
        end
        if (ph == PH_ENDED || ph == PH_CANCELLED) gesture_on = 1'b0;
      end
      if (r.report) begin
        r.guest_x = last_col;
        r.guest_y = last_row;
      end
      expected_reports.push_back(r);
    endfunction

    // compare a received report word with the oldest pending one
    function void check_report(touch_report_t got);
      touch_report_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: report word with none pending, expected none, got %p", $time, got);
        fails++;
        return;
      end
      want = expected_reports.pop_front();
      if (got.report !== want.report) begin
        $display("%0t: report mismatch, expected %0d, got %0d", $time, want.report,
                 got.report);
        fails++;
      end
      if (got.guest_x !== want.guest_x) begin
        $display("%0t: guest_x mismatch, expected %0d, got %0d", $time, want.guest_x,
                 got.guest_x);
        fails++;
      end
      if (got.guest_y !== want.guest_y) begin
        $display("%0t: guest_y mismatch, expected %0d, got %0d", $time, want.guest_y,
                 got.guest_y);
        fails++;
      end
      if (got.inside_res !== want.inside_res) begin
        $display("%0t: inside_res mismatch, expected %0d, got %0d", $time,
                 want.inside_res, got.inside_res);
        fails++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [1:0]       cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  ltm_evt_if evt ();
  ltm_res_if res ();

  touch_report_board board;
  bit                calm;
  bit                rx_hold_req;
  int                sent_in_phase;

  letterbox_touch_map_and_track_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .evt_i       (evt),
    .res_o       (res)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  // coordinate biased toward the view, its edges and its center
  function automatic logic signed [PT_W-1:0] near_coord(int span);
    int r, v;
    r = $urandom_range(0, 99);
    if (r < 65) v = $urandom_range(0, span);
    else if (r < 78) v = span / 2 - 128 + int'($urandom_range(0, 256));
    else if (r < 86) v = span - 32 + int'($urandom_range(0, 64));
    else if (r < 92) v = int'($urandom_range(0, 64)) - 32;
    else v = $urandom_range(0, (1 << PT_W) - 1);
    return v[PT_W-1:0];
  endfunction

  function automatic logic signed [PT_W-1:0] any_coord();
    return $urandom_range(0, (1 << PT_W) - 1);
  endfunction

  // drive one event word, starting at a falling edge
  task automatic send_touch(phase_e ph, logic signed [PT_W-1:0] px,
                            logic signed [PT_W-1:0] py);
    int gap;
    evt.cmd     = ph;
    evt.point_x = px;
    evt.point_y = py;
    evt.valid   = 1'b1;
    do @(posedge clk_i); while (evt.ready !== 1'b1);
    board.note_touch(ph, px, py);
    sent_in_phase++;
    @(negedge clk_i);
    gap = pick_gap();
    if (gap != 0) begin
      evt.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk_i);
    cfg_we = 1'b0;
    board.write_reg(idx, data);
  endtask

  // all four sizes; spare bits above the guest fields carry noise
  task automatic set_sizes(int vw, int vh, int gw, int gh);
    logic [2:0] hi_w, hi_h;
    hi_w = $urandom_range(0, 7);
    hi_h = $urandom_range(0, 7);
    write_reg(CFG_VIEW_WIDTH, vw[CFG_W-1:0]);
    write_reg(CFG_VIEW_HEIGHT, vh[CFG_W-1:0]);
    write_reg(CFG_GUEST_WIDTH, {hi_w, gw[GUEST_W-1:0]});
    write_reg(CFG_GUEST_HEIGHT, {hi_h, gh[GUEST_W-1:0]});
  endtask

  // hold the sender until every report is back, then let the mapper go quiet
  task automatic settle();
    evt.valid = 1'b0;
    while (board.expected_reports.size() != 0) @(posedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  // one well-formed gesture with random content
  task automatic play_gesture();
    int moves;
    send_touch(PH_BEGAN, near_coord(board.view_w), near_coord(board.view_h));
    moves = $urandom_range(0, 8);
    repeat (moves) begin
      if ($urandom_range(0, 9) < 3) send_touch(PH_MOVED, any_coord(), any_coord());
      else send_touch(PH_MOVED, near_coord(board.view_w), near_coord(board.view_h));
    end
    if ($urandom_range(0, 6) != 0)
      send_touch($urandom_range(0, 1) ? PH_ENDED : PH_CANCELLED,
                 near_coord(board.view_w), near_coord(board.view_h));
  endtask

  task automatic random_run(int quota);
    sent_in_phase = 0;
    while (sent_in_phase < quota) begin
      if ($urandom_range(0, 99) < 75) play_gesture();
      else send_touch(phase_e'($urandom_range(0, 3)), near_coord(board.view_w),
                      near_coord(board.view_h));
    end
  endtask

  // result side ready: random stalls, calm stretches, one long hold-off
  initial begin
    int n;
    bit r;
    res.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        r = 1'b0;
        n = 400;
      end else if (calm) begin
        r = 1'b1;
        n = 1;
      end else begin
        r = ($urandom_range(0, 99) < 65);
        n = pick_gap() + 1;
      end
      res.ready = r;
      repeat (n) @(negedge clk_i);
    end
  end

  // result check
  always @(posedge clk_i) begin
    if (rst_ni && res.valid === 1'b1 && res.ready === 1'b1)
      board.check_report(touch_report_t'{res.report, res.guest_x, res.guest_y,
                                         res.inside_res});
  end

  // main sequence
  initial begin
    int ph;
    board       = new();
    calm        = 1'b0;
    rx_hold_req = 1'b0;
    rst_ni      = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = CFG_VIEW_WIDTH;
    cfg_wdata   = '0;
    evt.valid   = 1'b0;
    evt.cmd     = PH_BEGAN;
    evt.point_x = '0;
    evt.point_y = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset sizes map sixteen points to a pixel: edges and tracker corners
    send_touch(PH_BEGAN, 0, 0);
    send_touch(PH_MOVED, 5119, 7679);
    send_touch(PH_MOVED, -1, 100);
    send_touch(PH_MOVED, 5120, 100);
    send_touch(PH_ENDED, -65536, -65536);
    send_touch(PH_MOVED, 800, 800);
    send_touch(PH_ENDED, 800, 800);
    send_touch(PH_BEGAN, 65535, 65535);
    send_touch(PH_CANCELLED, 100, 100);
    send_touch(PH_BEGAN, 1600, 3200);
    send_touch(PH_BEGAN, 6000, 0);
    send_touch(PH_MOVED, 100, 100);
    send_touch(PH_BEGAN, 16, 16);
    send_touch(PH_CANCELLED, 32, 48);
    send_touch(PH_BEGAN, 0, 7680);
    send_touch(PH_BEGAN, 5119, 0);
    send_touch(PH_MOVED, -65536, 65535);
    send_touch(PH_CANCELLED, 65535, -1);
    send_touch(PH_BEGAN, 2560, 3840);
    send_touch(PH_ENDED, 2561, 3841);
    settle();

    // size settings, extremes and degenerate ones included
    for (ph = 0; ph < 13; ph++) begin
      case (ph)
        0: set_sizes(5120, 7680, 320, 480);
        1: set_sizes(16000, 6000, 640, 480);
        2: set_sizes(65535, 65535, 4096, 4096);
        3: set_sizes(3000, 60000, 4096, 17);
        4: set_sizes(16, 16, 1, 1);
        5, 6, 7: set_sizes($urandom_range(1, 65535), $urandom_range(1, 65535),
                           $urandom_range(1, 4096), $urandom_range(1, 4096));
        8: set_sizes($urandom_range(256, 4000), $urandom_range(256, 4000),
                     $urandom_range(1, 8), $urandom_range(1, 8));
        9: set_sizes(0, 7680, 320, 480);
        10: set_sizes(5120, 0, 0, 480);
        11: set_sizes(5120, 7680, 320, 0);
        default: set_sizes(5120, 7680, 4097 + $urandom_range(0, 4094),
                           $urandom_range(4000, 8191));
      endcase
      calm = (ph == 2);
      if (ph == 4) rx_hold_req = 1'b1;
      random_run(ph < 9 ? 150 : 25);
      settle();
    end

    if (board.fails == 0 && board.expected_reports.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/ltm_pkg.sv
hw/rtl/ltm_if.sv
hw/rtl/ltm_alu.sv
hw/rtl/ltm_map.sv
hw/rtl/ltm_track.sv
hw/rtl/letterbox_touch_map_and_track_top.sv
dv/testbench.sv
